@@ design/spb_pkg.sv @@
// Shared constants and types for the small palette builder.
// No dependencies; imported by small_palette_builder.
`default_nettype none

package spb_pkg;

	localparam int SPB_ENTRIES = 16;   // default palette depth
	localparam int COLOR_W     = 32;
	localparam int INDEX_W     = 4;    // width of the index field
	localparam int COUNT_W     = 5;    // width of the color_count field
	localparam int MODE_W      = 2;
	localparam int OUT_FIELD_W = INDEX_W + 1 + 1 + COUNT_W + MODE_W;
	localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

	typedef logic [MODE_W-1:0] pack_mode_t;

	// bits per pixel of the packed image
	localparam pack_mode_t PM_ZERO_BIT = 2'd0;
	localparam pack_mode_t PM_ONE_BIT  = 2'd1;
	localparam pack_mode_t PM_TWO_BIT  = 2'd2;
	localparam pack_mode_t PM_FOUR_BIT = 2'd3;

	function automatic pack_mode_t mode_for_count(input logic [COUNT_W-1:0] count);
		pack_mode_t m;
		if (count > COUNT_W'(4)) begin
			m = PM_FOUR_BIT;
		end else if (count > COUNT_W'(2)) begin
			m = PM_TWO_BIT;
		end else if (count > COUNT_W'(1)) begin
			m = PM_ONE_BIT;
		end else begin
			m = PM_ZERO_BIT;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

@@ design/small_palette_builder.sv @@
// Small palette builder: per-image color palette lookup with sticky overflow.
// Depends on spb_pkg for field widths, pack mode codes and the mode function.
//
// Usage:
//   Slave channel (s_*): one RGBA pixel per word on s_tdata, s_tlast marks the
//   final pixel of an image. Master channel (m_*): one result word per pixel
//   with the palette index, new flag, overflow flag, palette size and packing
//   mode; m_tlast marks the result of the final pixel.
//   Each pixel is compared against all stored colors at once; an unseen color
//   takes the next free entry. Once the palette is full, a further new color
//   sets a sticky overflow and the rest of the image reports index 0. The last
//   pixel clears the palette and, unless overflowed, reports the packing mode.
//   Throughput: one pixel per clock while the receiver takes results; the
//   parallel compare is combinational between the input and result registers.
//   A pixel passes through the input register and then the result register.
//   Reset clears the palette count, overflow flag and both stage valids;
//   stored colors are not cleared, since only entries below the count are read.
//   When the receiver stalls, the result register holds and the input stage
//   still takes one more pixel; after that s_tready drops until m_tready.
`default_nettype none

module small_palette_builder
	import spb_pkg::*;
#(
	parameter int PALETTE_ENTRIES = SPB_ENTRIES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [COLOR_W-1:0]    s_tdata,   // [31:0] color
	input  wire logic                  s_tlast,   // last_pixel
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [3:0] index, [4] is_new, [5] overflow, [10:6] color_count, [12:11] pack_mode
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tlast    // image_done
);

	localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

	// input stage
	logic               valid_s1;
	logic [COLOR_W-1:0] color_s1;
	logic               last_s1;

	// palette state
	logic [COLOR_W-1:0] pal_q [PALETTE_ENTRIES];
	logic [CNT_W-1:0]   used_q;
	logic               ovf_q;

	// result register
	logic               out_valid_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic               out_new_q;
	logic               out_ovf_q;
	logic               out_done_q;
	logic [COUNT_W-1:0] out_count_q;
	pack_mode_t         out_mode_q;

	logic                       out_open;
	logic                       adv_s1;
	logic [PALETTE_ENTRIES-1:0] match;
	logic                       hit;
	logic [IDX_W-1:0]           hit_idx;
	logic                       full;
	logic [IDX_W-1:0]           idx_n;
	logic                       fresh_n;
	logic                       ovf_n;
	logic [CNT_W-1:0]           used_n;
	logic [COUNT_W-1:0]         count_n;
	pack_mode_t                 mode_n;

	assign out_open = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && out_open;
	assign s_tready = !valid_s1 || out_open;

	always_comb begin
		for (int k = 0; k < PALETTE_ENTRIES; k++) begin
			match[k] = (CNT_W'(k) < used_q) && (pal_q[k] == color_s1);
		end
	end

	assign hit = |match;

	// stored colors are distinct, so at most one entry matches
	always_comb begin
		hit_idx = '0;
		for (int k = PALETTE_ENTRIES - 1; k >= 0; k--) begin
			if (match[k]) begin
				hit_idx = IDX_W'(k);
			end
		end
	end

	assign full = (used_q == CNT_W'(PALETTE_ENTRIES));

	always_comb begin
		idx_n   = '0;
		fresh_n = 1'b0;
		ovf_n   = ovf_q;
		used_n  = used_q;
		if (!ovf_q) begin
			if (hit) begin
				idx_n = hit_idx;
			end else if (full) begin
				ovf_n = 1'b1;
			end else begin
				idx_n   = used_q[IDX_W-1:0];
				fresh_n = 1'b1;
				used_n  = used_q + CNT_W'(1);
			end
		end
	end

	assign count_n = COUNT_W'(used_n);
	assign mode_n  = (last_s1 && !ovf_n) ? mode_for_count(count_n) : PM_ZERO_BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			color_s1 <= s_tdata;
			last_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ovf_q  <= 1'b0;
		end else if (adv_s1) begin
			// close the image on its last pixel
			if (last_s1) begin
				used_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				used_q <= used_n;
				ovf_q  <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && fresh_n) begin
			pal_q[used_q[IDX_W-1:0]] <= color_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_open) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_idx_q   <= INDEX_W'(idx_n);
			out_new_q   <= fresh_n;
			out_ovf_q   <= ovf_n;
			out_done_q  <= last_s1;
			out_count_q <= count_n;
			out_mode_q  <= mode_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_done_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_mode_q, out_count_q, out_ovf_q,
		out_new_q, out_idx_q};

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(PALETTE_ENTRIES))
		else $error("palette count beyond depth");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> used_q == '0 && !ovf_q)
		else $error("palette not cleared after last pixel");

	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ovf_q |-> !out_new_q && out_idx_q == '0
			&& out_mode_q == PM_ZERO_BIT)
		else $error("overflowed result carries palette data");

	a_mode_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_mode_q != PM_ZERO_BIT |-> out_done_q)
		else $error("pack mode on a pixel that is not last");

	a_sticky_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ovf_q) && !$past(adv_s1 && last_s1) |-> ovf_q)
		else $error("overflow dropped inside an image");

endmodule

`default_nettype wire
